@@ rtl/core/i2p_pkg.sv @@
// shared types, character and operator codes, and helpers for the infix to postfix converter
package i2p_pkg;

	// ascii characters the converter recognizes or produces
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NULL  = 8'h00;

	// operator stack entry codes
	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;
	localparam logic [2:0] OP_LPAR = 3'd5;

	// error codes carried on a result beat
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_FULL      = 2'd1;
	localparam logic [1:0] ERR_UNMATCHED = 2'd2;

	// per-item result budget
	localparam int         RES_W       = 6;
	localparam logic [5:0] MAX_RESULTS = 6'd40;
	localparam logic [5:0] RES_LAST    = 6'd39;

	// commands from the controller to the datapath, valid for one cycle
	typedef struct packed {
		logic       load;
		logic       emit;
		logic [7:0] emit_char;
		logic       emit_has;
		logic       emit_last;
		logic [1:0] emit_err;
		logic       pop;
		logic       push;
		logic [2:0] push_code;
		logic       set_in_num;
		logic       clr_in_num;
		logic       set_pm;
		logic       clr_pm;
		logic       set_lock;
		logic       set_emitted;
		logic       clr_state;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic [7:0] ch;
		logic       end_item;
		logic [2:0] top_code;
		logic       empty;
		logic       full;
		logic       last_entry;
		logic       in_num;
		logic       pm;
		logic       emitted;
		logic       lock;
		logic       cnt_zero;
		logic       slot_ok;
	} status_t;

	function automatic logic [7:0] op_char(input logic [2:0] code);
		logic [7:0] c;
		case (code)
			OP_ADD:  c = CH_PLUS;
			OP_SUB:  c = CH_MINUS;
			OP_MUL:  c = CH_STAR;
			OP_DIV:  c = CH_SLASH;
			OP_LPAR: c = CH_LPAR;
			default: c = CH_NULL;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] op_prec(input logic [2:0] code);
		logic [1:0] p;
		case (code)
			OP_ADD, OP_SUB: p = 2'd1;
			OP_MUL, OP_DIV: p = 2'd2;
			default:        p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

@@ rtl/core/i2p_in_if.sv @@
// input channel: one infix character or end mark per beat
interface i2p_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_expr;

	modport source (output valid, output ch, output end_of_expr, input ready);
	modport sink (input valid, input ch, input end_of_expr, output ready);
endinterface

@@ rtl/core/i2p_out_if.sv @@
// output channel: one postfix character or marker per beat
interface i2p_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       has_char;
	logic       last;
	logic [1:0] error_code;

	modport source (output valid, output out_char, output has_char, output last,
		output error_code, input ready);
	modport sink (input valid, input out_char, input has_char, input last,
		input error_code, output ready);
endinterface

@@ rtl/core/infix_to_postfix_converter.sv @@
// top level of the infix to postfix converter
// Converts an infix expression, one ASCII character per input beat, into postfix text
// delivered one character per output beat, tokens separated by single spaces. An input
// beat with end_of_expr set flushes the operator stack, marks the final beat with last
// and returns the block to its reset state. A '-' is held until the next beat so that
// "-digit" becomes a signed number. A full stack or an unmatched ')' produces one beat
// with error_code set and has_char low; input is then ignored until end_of_expr, which
// yields a single empty last beat. Items are handled one at a time by a sequencer that
// takes one step per cycle unless an emitting step waits for output room: an item is
// accepted, then dispatched, then handled in steps that decode the character, emit the
// output beats and push or pop the stack; output back-pressure stretches only the steps
// that emit. At most 40 beats are produced per input beat; further beats of that item
// are dropped. There is no clearing pass after reset.
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	i2p_in_if.sink    infix,
	i2p_out_if.source postfix
);

	i2p_pkg::cmd_t    cmd;
	i2p_pkg::status_t st;
	logic             ctl_ready;

	// sequencer
	i2p_controller u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (infix.valid),
		.in_ready (ctl_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// stack, flags and output register
	i2p_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.st      (st),
		.in_ch   (infix.ch),
		.in_end  (infix.end_of_expr),
		.postfix (postfix)
	);

	assign infix.ready = ctl_ready;

`ifndef SYNTHESIS
	// an accepted beat keeps the sequencer busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(infix.valid && infix.ready) |=> !infix.ready)
		else $error("input accepted on two consecutive cycles");

	// a beat without a character carries a null character
	a_null_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(postfix.valid && !postfix.has_char) |-> (postfix.out_char == i2p_pkg::CH_NULL))
		else $error("marker beat carries a character");

	// an error beat never carries a character and holds a defined error code
	a_error_beat_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(postfix.valid && (postfix.error_code != i2p_pkg::ERR_NONE))
		|-> (!postfix.has_char && ((postfix.error_code == i2p_pkg::ERR_FULL) ||
		(postfix.error_code == i2p_pkg::ERR_UNMATCHED))))
		else $error("malformed error beat");
`endif

endmodule

@@ rtl/core/i2p_datapath.sv @@
// datapath: operator stack, parse flags, result counter and output register
module i2p_datapath #(
	parameter int STACK_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  i2p_pkg::cmd_t    cmd,
	output i2p_pkg::status_t st,
	input  logic [7:0]       in_ch,
	input  logic             in_end,
	i2p_out_if.source        postfix
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);

	logic [2:0]                 stack_q [STACK_DEPTH];
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           top_pos;
	logic [7:0]                 ch_q;
	logic                       end_q;
	logic                       in_num_q;
	logic                       pm_q;
	logic                       emitted_q;
	logic                       lock_q;
	logic [i2p_pkg::RES_W-1:0]  res_cnt_q;
	logic                       res_full;
	logic                       keep;
	logic                       out_valid_q;
	logic [7:0]                 out_char_q;
	logic                       out_has_q;
	logic                       out_last_q;
	logic [1:0]                 out_err_q;

	assign top_pos  = count_q - CNT_W'(1);
	assign res_full = (res_cnt_q == i2p_pkg::MAX_RESULTS);
	assign keep     = cmd.emit && !res_full;

	// status toward the controller
	always_comb begin
		st.ch         = ch_q;
		st.end_item   = end_q;
		st.top_code   = stack_q[top_pos[IDX_W-1:0]];
		st.empty      = (count_q == '0);
		st.full       = (count_q >= CNT_W'(STACK_DEPTH));
		st.last_entry = (count_q == CNT_W'(1));
		st.in_num     = in_num_q;
		st.pm         = pm_q;
		st.emitted    = emitted_q;
		st.lock       = lock_q;
		st.cnt_zero   = (res_cnt_q == '0);
		st.slot_ok    = res_full || !out_valid_q || postfix.ready;
	end

	// operator stack storage, entries below the count are the live ones
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_q[count_q[IDX_W-1:0]] <= cmd.push_code;
		end
	end

	// stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clr_state) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// current input beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q  <= in_ch;
			end_q <= in_end;
		end
	end

	// parse flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_num_q  <= 1'b0;
			pm_q      <= 1'b0;
			emitted_q <= 1'b0;
			lock_q    <= 1'b0;
		end else if (cmd.clr_state) begin
			in_num_q  <= 1'b0;
			pm_q      <= 1'b0;
			emitted_q <= 1'b0;
			lock_q    <= 1'b0;
		end else begin
			if (cmd.set_in_num) begin
				in_num_q <= 1'b1;
			end else if (cmd.clr_in_num) begin
				in_num_q <= 1'b0;
			end
			if (cmd.set_pm) begin
				pm_q <= 1'b1;
			end else if (cmd.clr_pm) begin
				pm_q <= 1'b0;
			end
			if (cmd.set_emitted) begin
				emitted_q <= 1'b1;
			end
			if (cmd.set_lock) begin
				lock_q <= 1'b1;
			end
		end
	end

	// results produced for the current item, saturating at the budget
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
		end else if (cmd.load) begin
			res_cnt_q <= '0;
		end else if (keep) begin
			res_cnt_q <= res_cnt_q + i2p_pkg::RES_W'(1);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (keep) begin
			out_valid_q <= 1'b1;
		end else if (postfix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload, the budget's final beat of an end item is marked last
	always_ff @(posedge clk) begin
		if (keep) begin
			out_char_q <= cmd.emit_char;
			out_has_q  <= cmd.emit_has;
			out_last_q <= cmd.emit_last || (end_q && (res_cnt_q == i2p_pkg::RES_LAST));
			out_err_q  <= cmd.emit_err;
		end
	end

	assign postfix.valid      = out_valid_q;
	assign postfix.out_char   = out_char_q;
	assign postfix.has_char   = out_has_q;
	assign postfix.last       = out_last_q;
	assign postfix.error_code = out_err_q;

endmodule

@@ rtl/core/i2p_controller.sv @@
// controller: shunting-yard sequencer issuing one datapath step per cycle unless an emitting step waits for output room
module i2p_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  i2p_pkg::status_t st,
	output i2p_pkg::cmd_t    cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_DISPATCH = 9'b000000010,
		S_PM_DIGIT = 9'b000000100,
		S_HANDLE   = 9'b000001000,
		S_OP_POP   = 9'b000010000,
		S_CLOSE    = 9'b000100000,
		S_FLUSH    = 9'b001000000,
		S_ERR      = 9'b010000000,
		S_END_MARK = 9'b100000000
	} state_t;

	// where to continue once an operator has been pushed
	typedef enum logic [1:0] {
		CTX_NONE = 2'd0,
		CTX_CHAR = 2'd1,
		CTX_END  = 2'd2
	} ctx_t;

	state_t             state_q, state_d;
	ctx_t               ctx_q, ctx_d;
	logic [2:0]         op_q, op_d;
	logic [1:0]         err_q, err_d;
	logic               sp_q, sp_d;
	logic               sp_phase;
	logic               go;
	logic [7:0]         top_char;
	i2p_pkg::cmd_t      raw;

	// next step and command
	always_comb begin
		raw      = '0;
		state_d  = state_q;
		ctx_d    = ctx_q;
		op_d     = op_q;
		err_d    = err_q;
		sp_d     = sp_q;
		in_ready = 1'b0;
		sp_phase = st.emitted && !sp_q;
		top_char = i2p_pkg::op_char(st.top_code);

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					raw.load = 1'b1;
					sp_d     = 1'b0;
					state_d  = S_DISPATCH;
				end
			end

			S_DISPATCH: begin
				if (st.end_item) begin
					if (st.lock) begin
						state_d = S_END_MARK;
					end else if (st.pm) begin
						raw.clr_pm = 1'b1;
						op_d       = i2p_pkg::OP_SUB;
						ctx_d      = CTX_END;
						state_d    = S_OP_POP;
					end else begin
						state_d = S_FLUSH;
					end
				end else if (st.lock) begin
					state_d = S_IDLE;
				end else if (st.pm) begin
					if (i2p_pkg::is_digit(st.ch)) begin
						// held minus becomes a sign token
						raw.emit     = 1'b1;
						raw.emit_has = 1'b1;
						if (sp_phase) begin
							raw.emit_char = i2p_pkg::CH_SPACE;
							sp_d          = 1'b1;
						end else begin
							raw.emit_char   = i2p_pkg::CH_MINUS;
							raw.set_emitted = 1'b1;
							raw.clr_pm      = 1'b1;
							sp_d            = 1'b0;
							state_d         = S_PM_DIGIT;
						end
					end else begin
						raw.clr_pm = 1'b1;
						op_d       = i2p_pkg::OP_SUB;
						ctx_d      = CTX_CHAR;
						state_d    = S_OP_POP;
					end
				end else begin
					state_d = S_HANDLE;
				end
			end

			S_PM_DIGIT: begin
				raw.emit       = 1'b1;
				raw.emit_has   = 1'b1;
				raw.emit_char  = st.ch;
				raw.set_in_num = 1'b1;
				state_d        = S_IDLE;
			end

			S_HANDLE: begin
				if (i2p_pkg::is_digit(st.ch)) begin
					raw.emit     = 1'b1;
					raw.emit_has = 1'b1;
					if (st.in_num) begin
						raw.emit_char = st.ch;
						state_d       = S_IDLE;
					end else if (sp_phase) begin
						raw.emit_char = i2p_pkg::CH_SPACE;
						sp_d          = 1'b1;
					end else begin
						raw.emit_char   = st.ch;
						raw.set_emitted = 1'b1;
						raw.set_in_num  = 1'b1;
						sp_d            = 1'b0;
						state_d         = S_IDLE;
					end
				end else begin
					raw.clr_in_num = 1'b1;
					state_d        = S_IDLE;
					unique case (st.ch)
						i2p_pkg::CH_MINUS: raw.set_pm = 1'b1;
						i2p_pkg::CH_LPAR: begin
							if (st.full) begin
								err_d   = i2p_pkg::ERR_FULL;
								state_d = S_ERR;
							end else begin
								raw.push      = 1'b1;
								raw.push_code = i2p_pkg::OP_LPAR;
							end
						end
						i2p_pkg::CH_RPAR: state_d = S_CLOSE;
						i2p_pkg::CH_PLUS: begin
							op_d    = i2p_pkg::OP_ADD;
							ctx_d   = CTX_NONE;
							state_d = S_OP_POP;
						end
						i2p_pkg::CH_STAR: begin
							op_d    = i2p_pkg::OP_MUL;
							ctx_d   = CTX_NONE;
							state_d = S_OP_POP;
						end
						i2p_pkg::CH_SLASH: begin
							op_d    = i2p_pkg::OP_DIV;
							ctx_d   = CTX_NONE;
							state_d = S_OP_POP;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end

			S_OP_POP: begin
				// pop entries of equal or higher precedence, then push
				if (!st.empty &&
					(i2p_pkg::op_prec(st.top_code) >= i2p_pkg::op_prec(op_q))) begin
					raw.emit     = 1'b1;
					raw.emit_has = 1'b1;
					if (sp_phase) begin
						raw.emit_char = i2p_pkg::CH_SPACE;
						sp_d          = 1'b1;
					end else begin
						raw.emit_char   = top_char;
						raw.set_emitted = 1'b1;
						raw.pop         = 1'b1;
						sp_d            = 1'b0;
					end
				end else if (st.full) begin
					err_d   = i2p_pkg::ERR_FULL;
					state_d = S_ERR;
				end else begin
					raw.push      = 1'b1;
					raw.push_code = op_q;
					case (ctx_q)
						CTX_CHAR: state_d = S_HANDLE;
						CTX_END:  state_d = S_FLUSH;
						default:  state_d = S_IDLE;
					endcase
				end
			end

			S_CLOSE: begin
				if (!st.empty && (st.top_code != i2p_pkg::OP_LPAR)) begin
					raw.emit     = 1'b1;
					raw.emit_has = 1'b1;
					if (sp_phase) begin
						raw.emit_char = i2p_pkg::CH_SPACE;
						sp_d          = 1'b1;
					end else begin
						raw.emit_char   = top_char;
						raw.set_emitted = 1'b1;
						raw.pop         = 1'b1;
						sp_d            = 1'b0;
					end
				end else if (st.empty) begin
					err_d   = i2p_pkg::ERR_UNMATCHED;
					state_d = S_ERR;
				end else begin
					// drop the matching open parenthesis
					raw.pop = 1'b1;
					state_d = S_IDLE;
				end
			end

			S_FLUSH: begin
				if (!st.empty) begin
					raw.emit     = 1'b1;
					raw.emit_has = 1'b1;
					if (sp_phase) begin
						raw.emit_char = i2p_pkg::CH_SPACE;
						sp_d          = 1'b1;
					end else begin
						raw.emit_char   = top_char;
						raw.emit_last   = st.last_entry;
						raw.set_emitted = 1'b1;
						raw.pop         = 1'b1;
						sp_d            = 1'b0;
					end
				end else if (st.cnt_zero) begin
					state_d = S_END_MARK;
				end else begin
					raw.clr_state = 1'b1;
					state_d       = S_IDLE;
				end
			end

			S_ERR: begin
				raw.emit       = 1'b1;
				raw.emit_char  = i2p_pkg::CH_NULL;
				raw.emit_err   = err_q;
				raw.set_lock   = 1'b1;
				raw.clr_pm     = 1'b1;
				raw.clr_in_num = 1'b1;
				state_d        = st.end_item ? S_END_MARK : S_IDLE;
			end

			S_END_MARK: begin
				raw.emit      = 1'b1;
				raw.emit_char = i2p_pkg::CH_NULL;
				raw.emit_last = 1'b1;
				raw.emit_err  = i2p_pkg::ERR_NONE;
				raw.clr_state = 1'b1;
				state_d       = S_IDLE;
			end

			default: state_d = S_IDLE;
		endcase
	end

	// a step that emits waits for room in the output register unless the result budget is spent
	assign go  = !raw.emit || st.slot_ok;
	assign cmd = go ? raw : '0;

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ctx_q   <= CTX_NONE;
			op_q    <= i2p_pkg::OP_NONE;
			err_q   <= i2p_pkg::ERR_NONE;
			sp_q    <= 1'b0;
		end else if (go) begin
			state_q <= state_d;
			ctx_q   <= ctx_d;
			op_q    <= op_d;
			err_q   <= err_d;
			sp_q    <= sp_d;
		end
	end

endmodule
